// ===== src/huffman_text_key_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Huffman text key decoder assertion macros
// Shared property templates for the checkers of the decoder unit.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TEXT_KEY_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TEXT_KEY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define HKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define HKD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder package
// Sizes, character codes, command and status codes, and shared types.
// ----------------------------------------------------------------------------
package hkd_pkg;

  localparam int NODE_COUNT      = 128;
  localparam int LETTER_COUNT    = 52;
  localparam int MAX_CODE_LENGTH = 30;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int NUSED_W = $clog2(NODE_COUNT + 1);
  localparam int LIDX_W  = $clog2(LETTER_COUNT + 1);
  localparam int CLEN_W  = $clog2(MAX_CODE_LENGTH + 1);

  localparam int ALPHA_SIZE  = 26;
  localparam int PUNCT_COUNT = 18;
  localparam int PUNCT_W     = $clog2(PUNCT_COUNT);

  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_TWO      = 8'h32;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_UC       = 8'h43;
  localparam logic [7:0] CH_UT       = 8'h54;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] DIGIT_SHIFT = 8'h02;

  // Punctuation emitted for code bytes C through T, in that order.
  localparam logic [7:0] PUNCT [PUNCT_COUNT] = '{
    8'h20, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h2D, 8'h21, 8'h3F, 8'h22,
    8'h27, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E
  };

  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_CODE = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } hkd_cmd_t;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_KEY_BAD  = 2'd1,
    ST_BAD_PATH = 2'd2
  } hkd_status_t;

  typedef enum logic [1:0] {
    LP_LETTER = 2'd0,
    LP_COLON  = 2'd1,
    LP_CODE   = 2'd2
  } hkd_linepos_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_EXEC = 1'b1
  } hkd_phase_t;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_EMIT      = 3'd1,
    OP_KEY_MOVE  = 3'd2,
    OP_KEY_NEW   = 3'd3,
    OP_CODE_STEP = 3'd4
  } hkd_op_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } hkd_kids_t;

  typedef struct packed {
    hkd_kids_t  kids;
    logic [7:0] letter;
  } hkd_node_t;

  typedef struct packed {
    logic              kid_we;
    logic [NODE_W-1:0] kid_waddr;
    hkd_kids_t         kid_wdata;
    logic              let_we;
    logic [NODE_W-1:0] let_waddr;
    logic [7:0]        let_wdata;
    logic              rd_en;
    logic [NODE_W-1:0] raddr;
  } hkd_mem_req_t;

  typedef struct packed {
    logic [7:0]  chr;
    hkd_status_t status;
  } hkd_result_t;

  function automatic logic [7:0] letter_of(input logic [LIDX_W-1:0] idx);
    logic [7:0] i8;
    i8 = 8'(idx);
    if (i8 < 8'(ALPHA_SIZE)) begin
      return CH_LA + i8;
    end
    return CH_UA + i8 - 8'(ALPHA_SIZE);
  endfunction

endpackage

// ===== src/huffman_text_key_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder unit
// Builds a code tree from key lines and decodes code bytes with it.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata (low bit up)   tuser (low bit up)
// in       slave      in_byte[7:0]         cmd[1:0]
// out      master     out_char[7:0]        status[1:0]
//
// Each input is taken in the idle phase, which may read a tree node through
// the node store's single read port; an execute phase then acts on the
// registered data. The root node lives in flip-flops, so reset needs no
// clearing pass. Results pass through an output register and one skid
// entry; input stalls in the execute phase or while the skid entry is full.
// ----------------------------------------------------------------------------
module huffman_text_key_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte[7:0]
  input  logic [1:0] in_tuser,   // cmd[1:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char[7:0]
  output logic [1:0] out_tuser   // status[1:0]
);

  hkd_pkg::hkd_mem_req_t mem_req;
  hkd_pkg::hkd_node_t    rd;
  hkd_pkg::hkd_result_t  push_data;
  hkd_pkg::hkd_result_t  out_res;
  logic                  push;
  logic                  room;

  hkd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_byte   (in_tdata),
    .room      (room),
    .mem_req   (mem_req),
    .rd        (rd),
    .push      (push),
    .push_data (push_data)
  );

  hkd_node_store u_store (
    .clk (clk),
    .req (mem_req),
    .rd  (rd)
  );

  hkd_result_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .room       (room)
  );

  assign out_tdata = out_res.chr;
  assign out_tuser = out_res.status;

endmodule

// ===== src/hkd_node_store.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder node store
// Child-link memory and letter memory of the code tree, one shared read port.
// ----------------------------------------------------------------------------
module hkd_node_store (
  input  logic                 clk,
  input  hkd_pkg::hkd_mem_req_t req,
  output hkd_pkg::hkd_node_t    rd
);

  hkd_pkg::hkd_kids_t kid_mem [hkd_pkg::NODE_COUNT];
  logic [7:0]         let_mem [hkd_pkg::NODE_COUNT];
  hkd_pkg::hkd_node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.kid_we) begin
      kid_mem[req.kid_waddr] <= req.kid_wdata;
    end
    if (req.let_we) begin
      let_mem[req.let_waddr] <= req.let_wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= '{kids: kid_mem[req.raddr], letter: let_mem[req.raddr]};
    end
  end

  assign rd = rd_data_r;

endmodule

// ===== src/hkd_result_buf.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder result buffer
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module hkd_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hkd_pkg::hkd_result_t push_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output hkd_pkg::hkd_result_t out_res,
  output logic                 room
);

  logic                 head_v_r, head_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  hkd_pkg::hkd_result_t head_r, head_nxt;
  hkd_pkg::hkd_result_t skid_r, skid_nxt;
  logic                 pop;

  assign pop = head_v_r & out_tready;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt = skid_r;
        if (push) begin
          skid_nxt = push_data;
        end else begin
          skid_v_nxt = 1'b0;
        end
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = head_v_r;
  assign out_res    = head_r;
  assign room       = ~skid_v_r;

endmodule

// ===== src/hkd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder control
// Key line parser, tree builder and code walker around the node store.
// ----------------------------------------------------------------------------
module hkd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_byte,
  input  logic                  room,
  output hkd_pkg::hkd_mem_req_t mem_req,
  input  hkd_pkg::hkd_node_t    rd,
  output logic                  push,
  output hkd_pkg::hkd_result_t  push_data
);

  localparam int NW = hkd_pkg::NODE_W;
  localparam int UW = hkd_pkg::NUSED_W;
  localparam int LW = hkd_pkg::LIDX_W;
  localparam int CW = hkd_pkg::CLEN_W;

  hkd_pkg::hkd_phase_t   phase_r, phase_nxt;
  hkd_pkg::hkd_op_t      op_r, op_nxt;
  hkd_pkg::hkd_linepos_t linepos_r, linepos_nxt;
  logic [UW-1:0]         nodes_used_r, nodes_used_nxt;
  logic [LW-1:0]         letter_idx_r, letter_idx_nxt;
  logic [CW-1:0]         code_len_r, code_len_nxt;
  logic [NW-1:0]         build_node_r, build_node_nxt;
  logic [NW-1:0]         decode_node_r, decode_node_nxt;
  logic                  lsc_r, lsc_nxt;
  logic                  broken_r, broken_nxt;
  logic [NW-1:0]         root_left_r, root_left_nxt;
  logic [NW-1:0]         root_right_r, root_right_nxt;
  hkd_pkg::hkd_kids_t    bkids_r, bkids_nxt;
  hkd_pkg::hkd_kids_t    dkids_r, dkids_nxt;
  hkd_pkg::hkd_result_t  res_r, res_nxt;
  logic [NW-1:0]         node_r, node_nxt;

  hkd_pkg::hkd_cmd_t     cmd;
  hkd_pkg::hkd_kids_t    root_kids;
  hkd_pkg::hkd_kids_t    cur_bkids;
  hkd_pkg::hkd_kids_t    cur_dkids;
  hkd_pkg::hkd_kids_t    new_bkids;
  logic                  accept;
  logic                  is_bit;
  logic                  bit_one;
  logic [NW-1:0]         slot;
  logic [NW-1:0]         dnext;
  logic [NW-1:0]         new_node;
  logic                  close_mark;
  logic [7:0]            close_letter;
  logic [7:0]            punct_off;

  assign cmd       = hkd_pkg::hkd_cmd_t'(in_cmd);
  assign in_tready = (phase_r == hkd_pkg::PH_IDLE) & room;
  assign accept    = in_tvalid & in_tready;

  assign root_kids = '{left: root_left_r, right: root_right_r};
  assign cur_bkids = (build_node_r == '0) ? root_kids : bkids_r;
  assign cur_dkids = (decode_node_r == '0) ? root_kids : dkids_r;

  assign is_bit   = (in_byte == hkd_pkg::CH_ZERO) || (in_byte == hkd_pkg::CH_ONE);
  assign bit_one  = (in_byte == hkd_pkg::CH_ONE);
  assign slot     = bit_one ? cur_bkids.right : cur_bkids.left;
  assign dnext    = bit_one ? cur_dkids.right : cur_dkids.left;
  assign new_node = nodes_used_r[NW-1:0];

  always_comb begin
    new_bkids = cur_bkids;
    if (bit_one) begin
      new_bkids.right = new_node;
    end else begin
      new_bkids.left = new_node;
    end
  end

  assign close_mark   = lsc_r && (letter_idx_r != '0);
  assign close_letter = hkd_pkg::letter_of(letter_idx_r - LW'(1));
  assign punct_off    = in_byte - hkd_pkg::CH_UC;

  always_comb begin
    unique case (phase_r)
      hkd_pkg::PH_IDLE: phase_nxt = accept ? hkd_pkg::PH_EXEC : hkd_pkg::PH_IDLE;
      hkd_pkg::PH_EXEC: phase_nxt = hkd_pkg::PH_IDLE;
      default:          phase_nxt = hkd_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    op_nxt          = op_r;
    linepos_nxt     = linepos_r;
    nodes_used_nxt  = nodes_used_r;
    letter_idx_nxt  = letter_idx_r;
    code_len_nxt    = code_len_r;
    build_node_nxt  = build_node_r;
    decode_node_nxt = decode_node_r;
    lsc_nxt         = lsc_r;
    broken_nxt      = broken_r;
    root_left_nxt   = root_left_r;
    root_right_nxt  = root_right_r;
    bkids_nxt       = bkids_r;
    dkids_nxt       = dkids_r;
    res_nxt         = res_r;
    node_nxt        = node_r;
    mem_req         = '0;
    push            = 1'b0;
    push_data       = '{chr: 8'd0, status: hkd_pkg::ST_CHAR};

    if (phase_r == hkd_pkg::PH_EXEC) begin
      case (op_r)
        hkd_pkg::OP_EMIT: begin
          push      = 1'b1;
          push_data = res_r;
        end
        hkd_pkg::OP_KEY_MOVE: begin
          bkids_nxt = rd.kids;
        end
        hkd_pkg::OP_KEY_NEW: begin
          mem_req.kid_we    = 1'b1;
          mem_req.kid_waddr = node_r;
          mem_req.kid_wdata = '0;
          mem_req.let_we    = 1'b1;
          mem_req.let_waddr = node_r;
          mem_req.let_wdata = 8'd0;
        end
        hkd_pkg::OP_CODE_STEP: begin
          if ((rd.kids.left != '0) || (rd.kids.right != '0)) begin
            decode_node_nxt = node_r;
            dkids_nxt       = rd.kids;
          end else begin
            decode_node_nxt = '0;
            push            = 1'b1;
            if (rd.letter == 8'd0) begin
              push_data.status = hkd_pkg::ST_BAD_PATH;
            end else begin
              push_data.chr = rd.letter;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      op_nxt  = hkd_pkg::OP_NONE;
      res_nxt = '{chr: 8'd0, status: hkd_pkg::ST_CHAR};
      unique case (cmd)
        hkd_pkg::CMD_KEY: begin
          if (!broken_r) begin
            case (linepos_r)
              hkd_pkg::LP_COLON: begin
                if (in_byte != hkd_pkg::CH_COLON) begin
                  broken_nxt     = 1'b1;
                  op_nxt         = hkd_pkg::OP_EMIT;
                  res_nxt.status = hkd_pkg::ST_KEY_BAD;
                end else begin
                  linepos_nxt = hkd_pkg::LP_CODE;
                end
              end
              hkd_pkg::LP_CODE: begin
                if (in_byte == hkd_pkg::CH_NL) begin
                  if (close_mark) begin
                    mem_req.let_we    = 1'b1;
                    mem_req.let_waddr = build_node_r;
                    mem_req.let_wdata = close_letter;
                  end
                  linepos_nxt = hkd_pkg::LP_LETTER;
                  lsc_nxt     = 1'b0;
                end else if (code_len_r >= CW'(hkd_pkg::MAX_CODE_LENGTH)) begin
                  broken_nxt     = 1'b1;
                  op_nxt         = hkd_pkg::OP_EMIT;
                  res_nxt.status = hkd_pkg::ST_KEY_BAD;
                end else begin
                  code_len_nxt = code_len_r + CW'(1);
                  lsc_nxt      = 1'b0;
                  if (is_bit) begin
                    if (slot == '0) begin
                      if (nodes_used_r >= UW'(hkd_pkg::NODE_COUNT)) begin
                        broken_nxt     = 1'b1;
                        op_nxt         = hkd_pkg::OP_EMIT;
                        res_nxt.status = hkd_pkg::ST_KEY_BAD;
                      end else begin
                        if (build_node_r == '0) begin
                          root_left_nxt  = new_bkids.left;
                          root_right_nxt = new_bkids.right;
                        end else begin
                          mem_req.kid_we    = 1'b1;
                          mem_req.kid_waddr = build_node_r;
                          mem_req.kid_wdata = new_bkids;
                          if (decode_node_r == build_node_r) begin
                            dkids_nxt = new_bkids;
                          end
                        end
                        bkids_nxt      = '0;
                        build_node_nxt = new_node;
                        node_nxt       = new_node;
                        nodes_used_nxt = nodes_used_r + UW'(1);
                        lsc_nxt        = 1'b1;
                        op_nxt         = hkd_pkg::OP_KEY_NEW;
                      end
                    end else begin
                      mem_req.rd_en  = 1'b1;
                      mem_req.raddr  = slot;
                      build_node_nxt = slot;
                      op_nxt         = hkd_pkg::OP_KEY_MOVE;
                    end
                  end
                end
              end
              default: begin
                if ((letter_idx_r >= LW'(hkd_pkg::LETTER_COUNT)) ||
                    (in_byte != hkd_pkg::letter_of(letter_idx_r))) begin
                  broken_nxt     = 1'b1;
                  op_nxt         = hkd_pkg::OP_EMIT;
                  res_nxt.status = hkd_pkg::ST_KEY_BAD;
                end else begin
                  letter_idx_nxt = letter_idx_r + LW'(1);
                  code_len_nxt   = '0;
                  build_node_nxt = '0;
                  lsc_nxt        = 1'b0;
                  linepos_nxt    = hkd_pkg::LP_COLON;
                end
              end
            endcase
          end
        end
        hkd_pkg::CMD_CODE: begin
          if (broken_r) begin
            op_nxt         = hkd_pkg::OP_EMIT;
            res_nxt.status = hkd_pkg::ST_KEY_BAD;
          end else if (is_bit) begin
            if (dnext == '0) begin
              decode_node_nxt = '0;
              op_nxt          = hkd_pkg::OP_EMIT;
              res_nxt.status  = hkd_pkg::ST_BAD_PATH;
            end else begin
              mem_req.rd_en = 1'b1;
              mem_req.raddr = dnext;
              node_nxt      = dnext;
              op_nxt        = hkd_pkg::OP_CODE_STEP;
            end
          end else if ((in_byte >= hkd_pkg::CH_TWO) && (in_byte <= hkd_pkg::CH_SEMI)) begin
            op_nxt      = hkd_pkg::OP_EMIT;
            res_nxt.chr = in_byte - hkd_pkg::DIGIT_SHIFT;
          end else if ((in_byte >= hkd_pkg::CH_UC) && (in_byte <= hkd_pkg::CH_UT)) begin
            op_nxt      = hkd_pkg::OP_EMIT;
            res_nxt.chr = hkd_pkg::PUNCT[punct_off[hkd_pkg::PUNCT_W-1:0]];
          end else if (in_byte == hkd_pkg::CH_NL) begin
            op_nxt      = hkd_pkg::OP_EMIT;
            res_nxt.chr = hkd_pkg::CH_NL;
          end
        end
        hkd_pkg::CMD_END: begin
          if (!broken_r) begin
            if (linepos_r == hkd_pkg::LP_COLON) begin
              broken_nxt     = 1'b1;
              op_nxt         = hkd_pkg::OP_EMIT;
              res_nxt.status = hkd_pkg::ST_KEY_BAD;
            end else begin
              if ((linepos_r == hkd_pkg::LP_CODE) && close_mark) begin
                mem_req.let_we    = 1'b1;
                mem_req.let_waddr = build_node_r;
                mem_req.let_wdata = close_letter;
              end
              if (linepos_r == hkd_pkg::LP_CODE) begin
                lsc_nxt = 1'b0;
              end
              linepos_nxt = hkd_pkg::LP_LETTER;
            end
          end
        end
        hkd_pkg::CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hkd_pkg::PH_IDLE;
      op_r          <= hkd_pkg::OP_NONE;
      linepos_r     <= hkd_pkg::LP_LETTER;
      nodes_used_r  <= UW'(1);
      letter_idx_r  <= '0;
      code_len_r    <= '0;
      build_node_r  <= '0;
      decode_node_r <= '0;
      lsc_r         <= 1'b0;
      broken_r      <= 1'b0;
      root_left_r   <= '0;
      root_right_r  <= '0;
    end else begin
      phase_r       <= phase_nxt;
      op_r          <= op_nxt;
      linepos_r     <= linepos_nxt;
      nodes_used_r  <= nodes_used_nxt;
      letter_idx_r  <= letter_idx_nxt;
      code_len_r    <= code_len_nxt;
      build_node_r  <= build_node_nxt;
      decode_node_r <= decode_node_nxt;
      lsc_r         <= lsc_nxt;
      broken_r      <= broken_nxt;
      root_left_r   <= root_left_nxt;
      root_right_r  <= root_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bkids_r <= bkids_nxt;
    dkids_r <= dkids_nxt;
    res_r   <= res_nxt;
    node_r  <= node_nxt;
  end

endmodule

// ===== src/hkd_checker.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder checker
// Port-level checks on the decoder unit, attached by bind.
// ----------------------------------------------------------------------------
`include "huffman_text_key_decoder_unit_defines.svh"

module hkd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  `HKD_ASSERT_IMPLY(a_err_char_zero, clk, rst_n, out_tvalid && (out_tuser != hkd_pkg::ST_CHAR), out_tdata == 8'd0, "error result carries a nonzero character")

  `HKD_ASSERT_NEXT(a_two_cycle_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted in two consecutive cycles")

  `HKD_ASSERT_ALWAYS_NEXT(a_reset_state, clk, !rst_n, !out_tvalid && in_tready, "unit not empty and ready after reset")

  `HKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind huffman_text_key_decoder_unit hkd_checker u_hkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Huffman text key decoder unit testbench
// Streams key lines and code bytes into the decoder under random idling on
// both sides. A scoreboard keeps its own copy of the code tree, predicts
// every result and checks the output stream against it in order.
// ----------------------------------------------------------------------------
module tb;
  import hkd_pkg::*;

  localparam logic [7:0] K_NL    = 8'h0A;
  localparam logic [7:0] K_COLON = 8'h3A;
  localparam logic [7:0] K_ZERO  = 8'h30;
  localparam logic [7:0] K_ONE   = 8'h31;
  localparam logic [7:0] K_TWO   = 8'h32;
  localparam logic [7:0] K_SEMI  = 8'h3B;
  localparam logic [7:0] K_UC    = 8'h43;
  localparam logic [7:0] K_UT    = 8'h54;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam int ALPHABET      = 26;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int TOTAL_ITEMS   = 1300;

  class code_tree_scoreboard;
    logic [NODE_W-1:0] left_kid [NODE_COUNT];
    logic [NODE_W-1:0] right_kid [NODE_COUNT];
    logic [7:0]        leaf_letter [NODE_COUNT];
    int                nodes_used;
    hkd_linepos_t      line_pos;
    int                letters_taken;
    int                code_len;
    int                build_at;
    bit                fresh_node;
    bit                broken;
    int                walk_at;
    hkd_result_t       due_results [$];
    int                mismatches;
    string             punct_set;

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        left_kid[i] = '0;
        right_kid[i] = '0;
        leaf_letter[i] = '0;
      end
      nodes_used = 1;
      line_pos = LP_LETTER;
      letters_taken = 0;
      code_len = 0;
      build_at = 0;
      fresh_node = 0;
      broken = 0;
      walk_at = 0;
      mismatches = 0;
      punct_set = " .,:;-!?\"'()[]{}<>";
    endfunction

    static function logic [7:0] letter_at(int idx);
      return (idx < ALPHABET) ? 8'(LOWER_A + idx) : 8'(UPPER_A + idx - ALPHABET);
    endfunction

    function void queue_result(logic [7:0] chr, hkd_status_t st);
      hkd_result_t r;
      r.chr = chr;
      r.status = st;
      due_results.push_back(r);
    endfunction

    function void key_error();
      broken = 1;
      queue_result(8'h00, ST_KEY_BAD);
    endfunction

    function void close_line();
      if (fresh_node && letters_taken > 0) begin
        leaf_letter[build_at] = letter_at(letters_taken - 1);
      end
      line_pos = LP_LETTER;
      fresh_node = 0;
    endfunction

    function void accept_item(hkd_cmd_t c, logic [7:0] b);
      int kid;
      case (c)
        CMD_KEY: begin
          if (broken) return;
          if (line_pos == LP_LETTER) begin
            if (letters_taken >= LETTER_COUNT || b != letter_at(letters_taken)) begin
              key_error();
              return;
            end
            letters_taken++;
            code_len = 0;
            build_at = 0;
            fresh_node = 0;
            line_pos = LP_COLON;
          end else if (line_pos == LP_COLON) begin
            if (b != K_COLON) key_error();
            else line_pos = LP_CODE;
          end else if (b == K_NL) begin
            close_line();
          end else if (code_len >= MAX_CODE_LENGTH) begin
            key_error();
          end else begin
            code_len++;
            fresh_node = 0;
            if (b == K_ZERO || b == K_ONE) begin
              kid = (b == K_ZERO) ? left_kid[build_at] : right_kid[build_at];
              if (kid == 0) begin
                if (nodes_used >= NODE_COUNT) begin
                  key_error();
                  return;
                end
                left_kid[nodes_used] = '0;
                right_kid[nodes_used] = '0;
                leaf_letter[nodes_used] = '0;
                kid = nodes_used;
                if (b == K_ZERO) left_kid[build_at] = NODE_W'(kid);
                else right_kid[build_at] = NODE_W'(kid);
                nodes_used++;
                fresh_node = 1;
              end
              build_at = kid;
            end
          end
        end
        CMD_CODE: begin
          if (broken) begin
            queue_result(8'h00, ST_KEY_BAD);
          end else if (b == K_ZERO || b == K_ONE) begin
            kid = (b == K_ZERO) ? left_kid[walk_at] : right_kid[walk_at];
            if (kid == 0) begin
              walk_at = 0;
              queue_result(8'h00, ST_BAD_PATH);
            end else if (left_kid[kid] != 0 || right_kid[kid] != 0) begin
              walk_at = kid;
            end else begin
              walk_at = 0;
              if (leaf_letter[kid] == 0) queue_result(8'h00, ST_BAD_PATH);
              else queue_result(leaf_letter[kid], ST_CHAR);
            end
          end else if (b >= K_TWO && b <= K_SEMI) begin
            queue_result(b - K_TWO + K_ZERO, ST_CHAR);
          end else if (b >= K_UC && b <= K_UT) begin
            queue_result(punct_set[b - K_UC], ST_CHAR);
          end else if (b == K_NL) begin
            queue_result(K_NL, ST_CHAR);
          end
        end
        CMD_END: begin
          if (broken) return;
          if (line_pos == LP_COLON) begin
            key_error();
          end else begin
            if (line_pos == LP_CODE) close_line();
            line_pos = LP_LETTER;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [7:0] chr, logic [1:0] st);
      hkd_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: out_char 0x%02h, status %0d", chr, st);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (chr !== want.chr) begin
        $error("out_char: expected 0x%02h, actual 0x%02h", want.chr, chr);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  code_tree_scoreboard sb;
  string letter_code [LETTER_COUNT];
  int    burst_left;
  int    items_sent;
  int    cycles;
  bit    long_hold;

  huffman_text_key_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[huffman_text_key_decoder_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_output(out_tdata, out_tuser);
    end
  end

  initial begin
    int seg;
    int mode;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      seg = $urandom_range(20, 60);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        @(negedge clk);
        if (long_hold) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          long_hold = 0;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic send(input hkd_cmd_t c, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.accept_item(c, b);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input hkd_cmd_t c, input string s);
    for (int i = 0; i < s.len(); i++) send(c, s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255));
    while (r == K_ZERO || r == K_ONE || r == K_NL);
    return r;
  endfunction

  task automatic key_line(input int n_bits, input bit with_noise, input bit spare_nodes);
    string bits;
    int    idx;
    logic [7:0] bit_ch;
    idx = sb.letters_taken;
    bits = "";
    if (spare_nodes && sb.nodes_used + n_bits > NODE_COUNT - 8) n_bits = 0;
    send(CMD_KEY, sb.letter_at(idx));
    send(CMD_KEY, K_COLON);
    for (int i = 0; i < n_bits; i++) begin
      if (with_noise && $urandom_range(0, 4) == 0) send(CMD_KEY, noise_char());
      bit_ch = $urandom_range(0, 1) ? K_ONE : K_ZERO;
      bits = {bits, string'(bit_ch)};
      send(CMD_KEY, bit_ch);
    end
    if (idx < LETTER_COUNT) letter_code[idx] = bits;
    if ($urandom_range(0, 4) == 0) send(CMD_END, 8'($urandom_range(0, 255)));
    else send(CMD_KEY, K_NL);
  endtask

  task automatic decode_some_letter();
    int    idx;
    string code;
    idx = $urandom_range(0, sb.letters_taken - 1);
    code = letter_code[idx];
    if (code.len() == 0) code = "0";
    for (int k = 0; k < code.len(); k++) send(CMD_CODE, code[k]);
  endtask

  initial begin
    int r;
    int kind;
    bit hold_done;
    bit pause_done;
    logic [7:0] b;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    burst_left = 0;
    items_sent = 0;
    cycles = 0;
    long_hold = 0;
    hold_done = 0;
    pause_done = 0;
    for (int i = 0; i < LETTER_COUNT; i++) letter_code[i] = "";
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(CMD_CODE, K_ZERO);
    send(CMD_CODE, K_TWO);
    send(CMD_CODE, K_SEMI);
    send(CMD_CODE, K_UC);
    send(CMD_CODE, K_UT);
    send(CMD_CODE, K_NL);
    send(CMD_CODE, 8'hFF);
    send(CMD_NONE, 8'hFF);
    send(CMD_END, 8'h00);
    send_text(CMD_KEY, "a:00\n");
    send_text(CMD_KEY, "b:01");
    send(CMD_END, 8'h00);
    send_text(CMD_KEY, "c:1x\n");
    letter_code[0] = "00";
    letter_code[1] = "01";
    letter_code[2] = "1";
    send_text(CMD_CODE, "00011");

    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent > 400) begin
        hold_done = 1;
        long_hold = 1;
        repeat (30) send(CMD_CODE, 8'($urandom_range(K_TWO, K_SEMI)));
      end
      if (!pause_done && items_sent > 650) begin
        pause_done = 1;
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 12 && sb.letters_taken < LETTER_COUNT) begin
        key_line($urandom_range(0, 6), $urandom_range(0, 7) == 0, 1'b1);
      end else if (r < 60) begin
        decode_some_letter();
      end else if (r < 78) begin
        repeat ($urandom_range(1, 8)) send(CMD_CODE, $urandom_range(0, 1) ? K_ONE : K_ZERO);
      end else if (r < 95) begin
        send(CMD_CODE, 8'($urandom_range(0, 255)));
      end else if (r < 98) begin
        send(CMD_END, 8'($urandom_range(0, 255)));
      end else begin
        send(CMD_NONE, 8'($urandom_range(0, 255)));
      end
    end

    kind = $urandom_range(0, 4);
    case (kind)
      0: begin
        do b = 8'($urandom_range(0, 255));
        while (sb.letters_taken < LETTER_COUNT && b == sb.letter_at(sb.letters_taken));
        send(CMD_KEY, b);
      end
      1: begin
        send(CMD_KEY, sb.letter_at(sb.letters_taken));
        if ($urandom_range(0, 1)) send(CMD_END, 8'h00);
        else begin
          do b = 8'($urandom_range(0, 255)); while (b == K_COLON);
          send(CMD_KEY, b);
        end
      end
      2: begin
        while (sb.letters_taken < LETTER_COUNT && !sb.broken) key_line(0, 1'b0, 1'b1);
        send(CMD_KEY, LOWER_A);
      end
      3: begin
        send(CMD_KEY, sb.letter_at(sb.letters_taken));
        send(CMD_KEY, K_COLON);
        repeat (MAX_CODE_LENGTH + 1) send(CMD_KEY, noise_char());
      end
      default: begin
        while (!sb.broken) key_line(MAX_CODE_LENGTH, 1'b0, 1'b0);
      end
    endcase
    while (!sb.broken) send(CMD_KEY, 8'h00);

    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) == 0) send(CMD_CODE, $urandom_range(0, 1) ? K_ONE : K_ZERO);
      else send(hkd_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("[huffman_text_key_decoder_unit] OK");
    end else begin
      $display("[huffman_text_key_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/hkd_pkg.sv
src/hkd_node_store.sv
src/hkd_result_buf.sv
src/hkd_ctrl.sv
src/huffman_text_key_decoder_unit.sv
src/hkd_checker.sv
bench/tb.sv
